/* src/ufct_pkg.sv */
package ufct_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_IGNORED      = 3'd0,
    ST_KNOWN        = 3'd1,
    ST_NEW          = 3'd2,
    ST_REMOVED      = 3'd3,
    ST_SHUT_UNKNOWN = 3'd4,
    ST_FULL         = 3'd5
  } status_t;

  localparam logic [15:0] SERVER_PORT_RESET = 16'd9090;
  localparam logic [63:0] SHUTDOWN_WORD     = 64'h5348_5554_444F_574E;
  localparam logic [15:0] SHUTDOWN_LEN      = 16'd8;
  localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;

  // One table entry as held in the memory
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] count;
  } entry_t;

  // One parsed datagram
  typedef struct packed {
    logic [63:0] payload_head;
    logic [15:0] payload_len;
    logic [15:0] dest_port;
    logic [15:0] sender_port;
    logic [31:0] src_ip;
  } item_t;

  // One result item
  typedef struct packed {
    logic [31:0] count;
    status_t     status;
  } res_t;

endpackage

/* src/ufct_mem.sv */
module ufct_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  ufct_pkg::entry_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output ufct_pkg::entry_t  rdata
);

  ufct_pkg::entry_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ufct_ctrl.sv */
module ufct_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       listen_port,
  input  logic              in_valid,
  output logic              in_ready,
  input  ufct_pkg::item_t   in_item,
  output logic              res_valid,
  input  logic              res_taken,
  output ufct_pkg::res_t    res,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output ufct_pkg::entry_t  mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  ufct_pkg::entry_t  mem_rdata
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_TAIL   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  state_t           state;
  logic [AW-1:0]    idx;
  logic             chk_vld;
  logic             hit;
  logic             free_found;
  logic [AW-1:0]    chk_idx;
  logic [AW-1:0]    hit_idx;
  logic [31:0]      hit_count;
  logic [AW-1:0]    free_idx;
  logic             shut;
  ufct_pkg::item_t  item;
  logic             accept;
  logic             rd_match;
  logic [31:0]      count_inc;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state == S_DONE);

  // Compare the entry returned by the memory against the captured sender.
  assign rd_match = chk_vld && mem_rdata.valid && (mem_rdata.addr == item.src_ip)
                    && (mem_rdata.port == item.sender_port);

  assign count_inc = (hit_count == ufct_pkg::COUNT_MAX) ? hit_count : hit_count + 32'd1;

  // Memory access: clearing writes, scan reads and the single update write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    mem_re    = (state == S_SCAN);
    mem_raddr = idx;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_DECIDE) begin
      if (hit) begin
        mem_we          = 1'b1;
        mem_waddr       = hit_idx;
        mem_wdata.valid = !shut;
        mem_wdata.addr  = item.src_ip;
        mem_wdata.port  = item.sender_port;
        mem_wdata.count = count_inc;
      end else if (!shut && free_found) begin
        mem_we          = 1'b1;
        mem_waddr       = free_idx;
        mem_wdata.valid = 1'b1;
        mem_wdata.addr  = item.src_ip;
        mem_wdata.port  = item.sender_port;
        mem_wdata.count = 32'd1;
      end
    end
  end

  // Sequencer: clear pass after reset, then one datagram at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      chk_vld    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            hit        <= 1'b0;
            free_found <= 1'b0;
            idx        <= '0;
            if (in_item.dest_port != listen_port) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_vld <= 1'b1;
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_TAIL;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_TAIL: begin
          chk_vld <= 1'b0;
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_taken) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
      // Record the first matching entry and the lowest free one.
      if (rd_match && !hit) begin
        hit <= 1'b1;
      end
      if (chk_vld && !mem_rdata.valid && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    chk_idx <= idx;
    if (accept) begin
      item       <= in_item;
      shut       <= (in_item.payload_len == ufct_pkg::SHUTDOWN_LEN)
                    && (in_item.payload_head == ufct_pkg::SHUTDOWN_WORD);
      res.status <= ufct_pkg::ST_IGNORED;
      res.count  <= '0;
    end
    if (rd_match && !hit) begin
      hit_idx   <= chk_idx;
      hit_count <= mem_rdata.count;
    end
    if (chk_vld && !mem_rdata.valid && !free_found) begin
      free_idx <= chk_idx;
    end
    if (state == S_DECIDE) begin
      if (hit && shut) begin
        res.status <= ufct_pkg::ST_REMOVED;
        res.count  <= '0;
      end else if (hit) begin
        res.status <= ufct_pkg::ST_KNOWN;
        res.count  <= count_inc;
      end else if (shut) begin
        res.status <= ufct_pkg::ST_SHUT_UNKNOWN;
        res.count  <= '0;
      end else if (free_found) begin
        res.status <= ufct_pkg::ST_NEW;
        res.count  <= 32'd1;
      end else begin
        res.status <= ufct_pkg::ST_FULL;
        res.count  <= '0;
      end
    end
  end

endmodule

/* src/udp_flow_counter_table.sv */
// Per-sender datagram counter table.
// Input items arrive on the s_ channel, one parsed UDP datagram each; every
// item gives exactly one result item on the m_ channel. The cfg channel
// writes the server port; it is always ready and should be used only while
// the block is idle.
// Datagrams for another port skip the table and are answered with the
// ignored status. A handled datagram reads all TABLE_DEPTH entries from
// the table memory, one entry per cycle through its single read port, then
// writes back at most once; the result is loaded into the output register
// and s_tready rises again in the same cycle, so only one item is worked
// on at a time. After reset a clearing pass empties every table entry while
// s_tready stays low; the server port returns to 9090.
// Results sit in an output register. If the receiver stalls, one result is
// held there, the next item is still accepted and worked on, and the block
// waits with its own result until the register is free again.
module udp_flow_counter_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // src_ip[31:0], sender_port[47:32], dest_port[63:48], payload_len[79:64],
  // payload_head[143:80]
  input  logic [143:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // status[2:0], count[34:3], zero fill[39:35]
  output logic [39:0]   m_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [15:0]       listen_port;
  ufct_pkg::item_t   in_item;
  ufct_pkg::res_t    res;
  logic              res_valid;
  logic              res_taken;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  ufct_pkg::entry_t  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  ufct_pkg::entry_t  mem_rdata;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      listen_port <= ufct_pkg::SERVER_PORT_RESET;
    end else if (cfg_valid) begin
      listen_port <= cfg_data;
    end
  end

  assign in_item = ufct_pkg::item_t'(s_tdata);

  ufct_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .listen_port (listen_port),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_item     (in_item),
    .res_valid   (res_valid),
    .res_taken   (res_taken),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  ufct_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: loads whenever it is empty or being emptied.
  assign res_taken = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_taken) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      m_tdata <= {5'd0, res.count, res.status};
    end
  end

`ifndef SYNTHESIS
  // Only one datagram is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice without a gap");

  // No item is taken while the clearing pass is running.
  a_clear_first: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during clearing pass");

  // Status code is within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'(ufct_pkg::ST_FULL)))
    else $error("undefined status code");

  // A count is reported only for counted datagrams.
  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != 3'(ufct_pkg::ST_KNOWN))
      && (m_tdata[2:0] != 3'(ufct_pkg::ST_NEW)) |-> (m_tdata[34:3] == 32'd0))
    else $error("nonzero count without counting");
`endif

endmodule
